// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the curve evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ppce_pkg.sv =====
// Types, codes and saturating Q16.16 helpers of the curve evaluator.
`timescale 1ns / 1ps
package ppce_pkg;

    typedef logic signed [31:0] t_q;

    typedef enum logic [1:0] {
        CMD_EVAL = 2'd0,
        CMD_POLY = 2'd1,
        CMD_HERM = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOCOEF  = 2'd2,
        ST_ZEROLEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_EVAL = 2'd0,
        OP_POLY = 2'd1,
        OP_HERM = 2'd2,
        OP_DONE = 2'd3
    } t_op;

    localparam logic [1:0] CFG_GAIN  = 2'd0;
    localparam logic [1:0] CFG_BIAS  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam t_q Q_MAX      = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN      = 32'sh8000_0000;
    localparam t_q GAIN_RESET = 32'sh0001_0000;
    localparam t_q BIAS_RESET = 32'sh0000_0000;
    localparam t_q LIMIT_RESET = 32'shFFFF_0000;

    typedef struct packed {
        t_q gain;
        t_q bias;
        t_q limit;
    } t_cfg;

    // One classified word as it waits in the queue.
    typedef struct packed {
        t_op        op;
        t_status    status;
        t_q         position;
        t_q         fallback;
        t_q         ca;
        t_q         cb;
        t_q         cc;
        t_q         cd;
        logic [2:0] count;
        t_q         lo;
        t_q         hi;
    } t_item;

    function automatic t_q sat33(input logic signed [32:0] x);
        if (x[32] == x[31]) return x[31:0];
        else if (x[32]) return Q_MIN;
        else return Q_MAX;
    endfunction

    function automatic t_q sat48(input logic signed [47:0] x);
        if ((&x[47:31]) || !(|x[47:31])) return x[31:0];
        else if (x[47]) return Q_MIN;
        else return Q_MAX;
    endfunction

    function automatic t_q q_add(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    // Floor shift of an exact product, then saturation.
    function automatic t_q q_mul_fin(input logic signed [63:0] p);
        return sat48(p[63:16]);
    endfunction

endpackage

// ===== hdl/ppce_if.sv =====
// Handshake interfaces of the command and result channels.
`timescale 1ns / 1ps
interface ppce_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic signed [31:0] position;
    logic signed [31:0] fallback_value;
    logic signed [31:0] coeff_a;
    logic signed [31:0] coeff_b;
    logic signed [31:0] coeff_c;
    logic signed [31:0] coeff_d;
    logic [2:0]        coeff_count;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;

    modport source (output valid, command, position, fallback_value, coeff_a, coeff_b,
                    coeff_c, coeff_d, coeff_count, bound_low, bound_high,
                    input ready);
    modport sink (input valid, command, position, fallback_value, coeff_a, coeff_b,
                  coeff_c, coeff_d, coeff_count, bound_low, bound_high,
                  output ready);
endinterface

interface ppce_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic              matched;
    logic [1:0]        status;

    modport source (output valid, value, matched, status, input ready);
    modport sink (input valid, value, matched, status, output ready);
endinterface

// ===== hdl/piecewise_poly_curve_eval_core.sv =====
// Top level of the piecewise polynomial curve evaluator.
//
// Channel   Dir  Handshake        Word
// i_item    in   valid/ready      command, position, fallback, coefficients, bounds
// o_res     out  valid/ready      value, matched, status
// i_cfg_*   in   write enable     register index and 32-bit data
//
// An evaluate word searches the segments one by one (one table read port,
// registered), then runs its Horner steps on the shared multiplier. A Hermite
// load runs five bit-serial divisions in a chain. Polynomial loads store their
// row directly, and rejected words go straight to the final state.
// A result that waits on the output holds the back end in its final state.
// Reset is synchronous, active low, and leaves the table empty; no clearing pass is
// needed. A two-word queue and the output register let the input side keep taking
// words while a result waits.
`timescale 1ns / 1ps
module piecewise_poly_curve_eval_core #(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_COEFFS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ppce_in_if.sink     i_item,
    ppce_out_if.source  o_res
);
    import ppce_pkg::*;

    localparam int UW = $clog2(MAX_SEGMENTS + 1);

    t_cfg          r_cfg;
    t_item         w_head;
    logic          w_head_valid;
    logic          w_pop;
    logic          w_div_start;
    t_q            w_div_num;
    t_q            w_div_den;
    logic          w_div_done;
    t_q            w_div_quot;
    logic [UW-1:0] w_used;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain  <= GAIN_RESET;
            r_cfg.bias  <= BIAS_RESET;
            r_cfg.limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:  r_cfg.gain  <= i_cfg_data;
                CFG_BIAS:  r_cfg.bias  <= i_cfg_data;
                CFG_LIMIT: r_cfg.limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front decodes commands and settles rejects that need no table state.
    ppce_front #(
        .MAX_COEFFS(MAX_COEFFS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_head      (w_head),
        .o_head_valid(w_head_valid),
        .i_pop       (w_pop)
    );

    // The back owns the table and runs one word at a time.
    ppce_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .MAX_COEFFS  (MAX_COEFFS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (w_head),
        .i_head_valid(w_head_valid),
        .o_pop       (w_pop),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .o_div_den   (w_div_den),
        .i_div_done  (w_div_done),
        .i_div_quot  (w_div_quot),
        .o_used      (w_used),
        .o_res       (o_res)
    );

    ppce_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

`include "assert_macros.svh"

    // A rejected load reports neither a value nor a match.
    `ASSERT_IMPLY(a_reject_clean, i_clk, i_rst_n, o_res.valid && (o_res.status != ST_OK), (o_res.value == 32'sh0) && !o_res.matched)
    // The table only grows, one segment at a time.
    `ASSERT_NEXT(a_used_step, i_clk, i_rst_n, 1'b1, (w_used == $past(w_used)) || (w_used == $past(w_used) + UW'(1)))
    // A match can only come from a filled table.
    `ASSERT_IMPLY(a_hit_has_table, i_clk, i_rst_n, o_res.valid && o_res.matched, w_used != '0)

endmodule

// ===== hdl/ppce_front.sv =====
// Front end: accepts command words, classifies them and queues them.
`timescale 1ns / 1ps
module ppce_front #(
    parameter int MAX_COEFFS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppce_in_if.sink         i_item,
    output ppce_pkg::t_item o_head,
    output logic            o_head_valid,
    input  logic            i_pop
);
    import ppce_pkg::*;

    localparam int QD = 2;

    t_item      r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_cls;
    logic       w_push;

    // Rejects that need no table state are settled here.
    always_comb begin
        w_cls.op       = OP_DONE;
        w_cls.status   = ST_OK;
        w_cls.position = i_item.position;
        w_cls.fallback = i_item.fallback_value;
        w_cls.ca       = i_item.coeff_a;
        w_cls.cb       = i_item.coeff_b;
        w_cls.cc       = i_item.coeff_c;
        w_cls.cd       = i_item.coeff_d;
        w_cls.count    = (i_item.coeff_count > 3'(MAX_COEFFS)) ? 3'(MAX_COEFFS)
                                                                : i_item.coeff_count;
        w_cls.lo       = i_item.bound_low;
        w_cls.hi       = i_item.bound_high;
        unique case (t_cmd'(i_item.command))
            CMD_EVAL: w_cls.op = OP_EVAL;
            CMD_POLY: begin
                if (i_item.coeff_count == 3'd0) w_cls.status = ST_NOCOEF;
                else w_cls.op = OP_POLY;
            end
            CMD_HERM: begin
                if (i_item.bound_high == i_item.bound_low) w_cls.status = ST_ZEROLEN;
                else w_cls.op = OP_HERM;
            end
            CMD_NOP: w_cls.op = OP_DONE;
        endcase
    end

    assign i_item.ready = (r_cnt != 2'(QD));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (w_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!w_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// ===== hdl/ppce_div.sv =====
// Bit-serial saturating Q16.16 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppce_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  ppce_pkg::t_q i_num,
    input  ppce_pkg::t_q i_den,
    output logic         o_done,
    output ppce_pkg::t_q o_quot
);
    import ppce_pkg::*;

    localparam int NB = 48;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [31:0]       r_rem;
    logic [NB-1:0]     r_quo;
    logic [31:0]       r_den;
    logic              r_neg;
    logic [32:0]       w_rem_sh;
    logic [33:0]       w_diff;
    logic [31:0]       w_num_mag;
    logic [31:0]       w_den_mag;

    assign w_num_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_den_mag = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign w_rem_sh  = {r_rem, r_quo[NB-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= {w_num_mag, 16'h0000};
            r_den <= w_den_mag;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[NB-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_quo <= {r_quo[NB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            if ((|r_quo[NB-1:32]) || (r_quo[31] && (|r_quo[30:0]))) o_quot = Q_MIN;
            else o_quot = -$signed(r_quo[31:0]);
        end else begin
            if (|r_quo[NB-1:31]) o_quot = Q_MAX;
            else o_quot = r_quo[31:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== hdl/ppce_back.sv =====
// Back end: segment table, search, Horner evaluation and Hermite loading.
`timescale 1ns / 1ps
module ppce_back #(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_COEFFS   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppce_pkg::t_cfg                 i_cfg,
    input  ppce_pkg::t_item                i_head,
    input  logic                           i_head_valid,
    output logic                           o_pop,
    output logic                           o_div_start,
    output ppce_pkg::t_q                   o_div_num,
    output ppce_pkg::t_q                   o_div_den,
    input  logic                           i_div_done,
    input  ppce_pkg::t_q                   i_div_quot,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0] o_used,
    ppce_out_if.source                     o_res
);
    import ppce_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int UW = $clog2(MAX_SEGMENTS + 1);
    localparam int OW = $clog2(MAX_COEFFS + 1);
    localparam int KW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    typedef struct packed {
        logic [MAX_COEFFS-1:0][31:0] coef;
        logic [OW-1:0]               order;
        t_q                          lo;
        t_q                          hi;
        t_q                          org;
    } t_row;

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_E_WAIT  = 17'h00002,
        S_E_CHK   = 17'h00004,
        S_E_REL   = 17'h00008,
        S_E_MUL   = 17'h00010,
        S_E_ACC   = 17'h00020,
        S_E_GM    = 17'h00040,
        S_E_GA    = 17'h00080,
        S_E_CLAMP = 17'h00100,
        S_H_P1    = 17'h00200,
        S_H_P2    = 17'h00400,
        S_H_P3    = 17'h00800,
        S_H_N2    = 17'h01000,
        S_H_N3    = 17'h02000,
        S_H_DIV   = 17'h04000,
        S_STORE   = 17'h08000,
        S_FIN     = 17'h10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_row                r_mem [MAX_SEGMENTS];
    t_row                r_rd;
    t_row                w_row;
    logic [IW-1:0]       r_idx;
    logic [UW-1:0]       r_used;
    t_item               r_it;
    t_q                  r_c [4];
    t_q                  r_v;
    t_q                  r_rel;
    logic [KW-1:0]       r_k;
    logic                r_hit;
    t_status             r_status;
    t_q                  r_len;
    t_q                  r_dy;
    t_q                  r_dy2;
    t_q                  r_ndy;
    t_q                  r_t2;
    t_q                  r_t3;
    t_q                  r_n2;
    t_q                  r_n3;
    logic [2:0]          r_dstep;
    logic signed [63:0]  r_prod;
    t_q                  w_mul_a;
    t_q                  w_mul_b;
    t_q                  w_mul;
    logic                w_full;
    logic                w_in_seg;
    logic                w_last;
    logic [2:0]          w_n;
    logic                w_out_free;
    logic                r_ov;
    t_q                  r_o_value;
    logic                r_o_matched;
    t_status             r_o_status;

    assign w_full     = (r_used == UW'(MAX_SEGMENTS));
    assign w_in_seg   = (r_it.position >= r_rd.lo) && (r_it.position < r_rd.hi);
    assign w_last     = ((UW'(r_idx) + UW'(1)) == r_used);
    assign w_mul      = q_mul_fin(r_prod);
    assign w_out_free = !r_ov || o_res.ready;
    assign o_pop      = (r_state == S_IDLE) && i_head_valid;
    assign o_used     = r_used;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.op)
                        OP_EVAL: n_state = (r_used == '0) ? S_E_GM : S_E_WAIT;
                        OP_POLY: n_state = w_full ? S_FIN : S_STORE;
                        OP_HERM: n_state = w_full ? S_FIN : S_H_P1;
                        OP_DONE: n_state = S_FIN;
                    endcase
                end
            end
            S_E_WAIT:  n_state = S_E_CHK;
            S_E_CHK: begin
                if (w_in_seg) n_state = S_E_REL;
                else if (w_last) n_state = S_E_GM;
                else n_state = S_E_WAIT;
            end
            S_E_REL:   n_state = (r_rd.order == OW'(1)) ? S_E_GM : S_E_MUL;
            S_E_MUL:   n_state = S_E_ACC;
            S_E_ACC:   n_state = (r_k == KW'(1)) ? S_E_GM : S_E_MUL;
            S_E_GM:    n_state = S_E_GA;
            S_E_GA:    n_state = S_E_CLAMP;
            S_E_CLAMP: n_state = S_FIN;
            S_H_P1:    n_state = S_H_P2;
            S_H_P2:    n_state = S_H_P3;
            S_H_P3:    n_state = S_H_N2;
            S_H_N2:    n_state = S_H_N3;
            S_H_N3:    n_state = S_H_DIV;
            S_H_DIV:   n_state = (i_div_done && r_dstep == 3'd4) ? S_STORE : S_H_DIV;
            S_STORE:   n_state = S_FIN;
            S_FIN:     n_state = w_out_free ? S_IDLE : S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    // Shared multiplier operands.
    always_comb begin
        case (r_state)
            S_E_MUL: begin w_mul_a = r_v;        w_mul_b = r_rel; end
            S_E_GM:  begin w_mul_a = i_cfg.gain; w_mul_b = r_v;   end
            S_H_P3:  begin w_mul_a = r_len;      w_mul_b = r_t2;  end
            S_H_N2:  begin w_mul_a = r_len;      w_mul_b = r_t3;  end
            default: begin w_mul_a = '0;         w_mul_b = '0;    end
        endcase
    end

    // Divider chain: n2/L/L, then n3/L/L/L.
    always_comb begin
        o_div_start = (r_state == S_H_N3) ||
                      ((r_state == S_H_DIV) && i_div_done && (r_dstep != 3'd4));
        o_div_den   = r_len;
        if (r_state == S_H_N3) o_div_num = r_n2;
        else if (r_dstep == 3'd1) o_div_num = r_n3;
        else o_div_num = i_div_quot;
    end

    always_comb begin
        w_n = (r_it.op == OP_POLY) ? r_it.count : 3'(MAX_COEFFS);
        for (int k = 0; k < MAX_COEFFS; k++) begin
            w_row.coef[k] = (3'(k) < w_n) ? r_c[k] : 32'h0;
        end
        w_row.order = OW'(w_n);
        w_row.lo    = r_it.lo;
        w_row.hi    = r_it.hi;
        w_row.org   = (r_it.op == OP_POLY) ? 32'sh0 : r_it.lo;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) r_mem[r_used[IW-1:0]] <= w_row;
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_STORE) r_used <= r_used + UW'(1);
            if (r_state == S_FIN && w_out_free) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            S_IDLE: begin
                r_it     <= i_head;
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_status <= (i_head.op == OP_DONE) ? i_head.status
                          : ((i_head.op != OP_EVAL) && w_full) ? ST_FULL : ST_OK;
                r_v      <= (i_head.op == OP_EVAL) ? i_head.fallback : 32'sh0;
                r_c[0]   <= i_head.ca;
                r_c[1]   <= i_head.cb;
                r_c[2]   <= i_head.cc;
                r_c[3]   <= i_head.cd;
            end
            S_E_CHK: begin
                if (!w_in_seg && !w_last) r_idx <= r_idx + IW'(1);
            end
            S_E_REL: begin
                r_rel <= q_sub(r_it.position, r_rd.org);
                r_k   <= KW'(r_rd.order - OW'(1));
                r_v   <= r_rd.coef[KW'(r_rd.order - OW'(1))];
                r_hit <= 1'b1;
            end
            S_E_ACC: begin
                r_v <= q_add(w_mul, r_rd.coef[r_k - KW'(1)]);
                r_k <= r_k - KW'(1);
            end
            S_E_GA: r_v <= q_add(w_mul, i_cfg.bias);
            S_E_CLAMP: begin
                if (i_cfg.limit > 32'sh0) begin
                    if (r_v > i_cfg.limit) r_v <= i_cfg.limit;
                    else if (r_v < -i_cfg.limit) r_v <= -i_cfg.limit;
                end
            end
            S_H_P1: begin
                r_len  <= q_sub(r_it.hi, r_it.lo);
                r_dy   <= q_sub(r_it.cb, r_it.cd);
                r_ndy  <= q_sub(r_it.cd, r_it.cb);
                r_t2   <= q_add(r_it.cc, r_it.cc);
                r_t3   <= q_add(r_it.cc, r_it.ca);
                r_c[0] <= r_it.cd;
                r_c[1] <= r_it.cc;
            end
            S_H_P2: begin
                r_t2  <= q_add(r_t2, r_it.ca);
                r_dy2 <= q_add(r_dy, r_dy);
                r_ndy <= q_add(r_ndy, r_ndy);
            end
            S_H_P3: r_dy2 <= q_add(r_dy2, r_dy);
            S_H_N2: r_n2 <= q_sub(r_dy2, w_mul);
            S_H_N3: begin
                r_n3    <= q_add(r_ndy, w_mul);
                r_dstep <= 3'd0;
            end
            S_H_DIV: begin
                if (i_div_done) begin
                    r_dstep <= r_dstep + 3'd1;
                    if (r_dstep == 3'd1) r_c[2] <= i_div_quot;
                    if (r_dstep == 3'd4) r_c[3] <= i_div_quot;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_o_value   <= r_v;
                    r_o_matched <= r_hit;
                    r_o_status  <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid   = r_ov;
    assign o_res.value   = r_o_value;
    assign o_res.matched = r_o_matched;
    assign o_res.status  = r_o_status;

endmodule

// ===== bench/piecewise_poly_curve_eval_core_test.sv =====
// Self-checking testbench of the piecewise polynomial curve evaluator.
`timescale 1ns / 1ps
module piecewise_poly_curve_eval_core_test;
    import ppce_pkg::*;

    localparam int NSEG = 16;
    localparam int NCOEF = 4;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int RANDOM_WORDS = 1380;
    localparam int CALM_WORDS = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    ppce_in_if item_ch ();
    ppce_out_if res_ch ();

    piecewise_poly_curve_eval_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(item_ch.sink), .o_res(res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // One command word and one result word as the bench sees them.
    typedef struct {
        t_cmd cmd;
        t_q pos, fb, ca, cb, cc, cd;
        logic [2:0] cnt;
        t_q lo, hi;
    } t_word;

    typedef struct {
        t_q value;
        logic matched;
        logic [1:0] status;
    } t_result;

    // Shadow copy of the curve table and registers.
    t_q tbl_coef [NSEG][NCOEF];
    t_q tbl_lo [NSEG];
    t_q tbl_hi [NSEG];
    t_q tbl_org [NSEG];
    int tbl_order [NSEG];
    int tbl_used;
    t_q sh_gain, sh_bias, sh_limit;

    t_result pending_results[$];
    int fail_count = 0;
    int cycle_count = 0;
    int rx_idle = 0;
    bit calm = 1'b0;
    bit hold_long = 1'b0;

    function automatic t_q sat64(input longint x);
        if (x > 64'sd2147483647) return Q_MAX;
        if (x < -64'sd2147483648) return Q_MIN;
        return t_q'(x);
    endfunction

    function automatic t_q fx_add(input t_q a, input t_q b);
        return sat64(longint'(a) + longint'(b));
    endfunction

    function automatic t_q fx_sub(input t_q a, input t_q b);
        return sat64(longint'(a) - longint'(b));
    endfunction

    // Exact product, then arithmetic shift (floor) by 16.
    function automatic t_q fx_mul(input t_q a, input t_q b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat64(p >>> 16);
    endfunction

    // Quotient truncated toward zero; the divisor is never zero here.
    function automatic t_q fx_div(input t_q a, input t_q b);
        longint n;
        n = longint'(a) * 65536;
        return sat64(n / longint'(b));
    endfunction

    function automatic logic [1:0] table_append(input t_q c [NCOEF], input int n,
                                                input t_q lo, input t_q hi, input t_q org);
        if (tbl_used >= NSEG) return ST_FULL;
        for (int k = 0; k < NCOEF; k++) tbl_coef[tbl_used][k] = (k < n) ? c[k] : '0;
        tbl_lo[tbl_used] = lo;
        tbl_hi[tbl_used] = hi;
        tbl_org[tbl_used] = org;
        tbl_order[tbl_used] = n;
        tbl_used++;
        return ST_OK;
    endfunction

    // Predicts one result word and updates the shadow table.
    function automatic t_result curve_outcome(input t_word w);
        t_result r;
        t_q v, rel, len, dy, ndy, n2, n3;
        t_q c [NCOEF];
        int n;
        r.value = '0;
        r.matched = 1'b0;
        r.status = ST_OK;
        case (w.cmd)
            CMD_EVAL: begin
                v = w.fb;
                for (int s = 0; s < tbl_used; s++) begin
                    if (w.pos >= tbl_lo[s] && w.pos < tbl_hi[s]) begin
                        n = tbl_order[s];
                        rel = fx_sub(w.pos, tbl_org[s]);
                        v = tbl_coef[s][n - 1];
                        for (int k = n - 1; k > 0; k--)
                            v = fx_add(fx_mul(v, rel), tbl_coef[s][k - 1]);
                        r.matched = 1'b1;
                        break;
                    end
                end
                v = fx_add(fx_mul(sh_gain, v), sh_bias);
                if (sh_limit > 0) begin
                    if (v > sh_limit) v = sh_limit;
                    else if (v < -sh_limit) v = -sh_limit;
                end
                r.value = v;
            end
            CMD_POLY: begin
                if (w.cnt == 0) begin
                    r.status = ST_NOCOEF;
                end else begin
                    n = (w.cnt > NCOEF) ? NCOEF : int'(w.cnt);
                    c[0] = w.ca; c[1] = w.cb; c[2] = w.cc; c[3] = w.cd;
                    r.status = table_append(c, n, w.lo, w.hi, '0);
                end
            end
            CMD_HERM: begin
                if (w.hi == w.lo) begin
                    r.status = ST_ZEROLEN;
                end else begin
                    len = fx_sub(w.hi, w.lo);
                    dy = fx_sub(w.cb, w.cd);
                    ndy = fx_sub(w.cd, w.cb);
                    n2 = fx_sub(fx_add(fx_add(dy, dy), dy),
                                fx_mul(len, fx_add(fx_add(w.cc, w.cc), w.ca)));
                    n3 = fx_add(fx_add(ndy, ndy), fx_mul(len, fx_add(w.cc, w.ca)));
                    c[0] = w.cd;
                    c[1] = w.cc;
                    c[2] = fx_div(fx_div(n2, len), len);
                    c[3] = fx_div(fx_div(fx_div(n3, len), len), len);
                    r.status = table_append(c, NCOEF, w.lo, w.hi, w.lo);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sender: one word per call, with random bursts of idle before it.
    // Valid stays high between back-to-back words and drops only for idling.
    task automatic offer_word(input t_word w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= w.cmd;
        item_ch.position <= w.pos;
        item_ch.fallback_value <= w.fb;
        item_ch.coeff_a <= w.ca;
        item_ch.coeff_b <= w.cb;
        item_ch.coeff_c <= w.cc;
        item_ch.coeff_d <= w.cd;
        item_ch.coeff_count <= w.cnt;
        item_ch.bound_low <= w.lo;
        item_ch.bound_high <= w.hi;
        do @(posedge i_clk); while (!item_ch.ready);
        pending_results.push_back(curve_outcome(w));
    endtask

    task automatic settle_idle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // The longest busy stretch of the block comes from a Hermite load.
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input t_q data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN: sh_gain = data;
            CFG_BIAS: sh_bias = data;
            default: sh_limit = data;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_q rand_q();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return t_q'($urandom_range(0, 65536 * 8)) - 32'sd262144;
            default: return t_q'($urandom);
        endcase
    endfunction

    function automatic t_word blank_word(input t_cmd c);
        t_word w;
        w.cmd = c;
        w.pos = '0; w.fb = '0; w.ca = '0; w.cb = '0; w.cc = '0; w.cd = '0;
        w.cnt = '0; w.lo = '0; w.hi = '0;
        return w;
    endfunction

    // Mostly well-formed words over a small range so that lookups hit the table.
    function automatic t_word random_word();
        t_word w;
        int pick;
        w.pos = rand_q(); w.fb = t_q'($urandom); w.ca = rand_q(); w.cb = rand_q();
        w.cc = rand_q(); w.cd = rand_q(); w.cnt = 3'($urandom);
        w.lo = rand_q(); w.hi = rand_q();
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            w.cmd = CMD_EVAL;
            if ($urandom_range(0, 3) != 0)
                w.pos = t_q'($urandom_range(0, 65536 * 16)) - 32'sd524288;
        end else if (pick < 16) begin
            w.cmd = CMD_POLY;
            if ($urandom_range(0, 2) != 0) begin
                w.lo = t_q'($urandom_range(0, 65536 * 8)) - 32'sd524288;
                w.hi = w.lo + t_q'($urandom_range(1, 65536 * 8));
            end
        end else if (pick < 19) begin
            w.cmd = CMD_HERM;
            if ($urandom_range(0, 5) == 0) w.hi = w.lo;
            else if ($urandom_range(0, 2) != 0) begin
                w.lo = t_q'($urandom_range(0, 65536 * 8)) - 32'sd524288;
                w.hi = w.lo + t_q'($urandom_range(1, 65536 * 8));
            end
        end else begin
            w.cmd = CMD_NOP;
        end
        return w;
    endfunction

    // Receiver: random stall bursts, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_long) begin
            res_ch.ready <= 1'b0;
        end else if (calm) begin
            res_ch.ready <= 1'b1;
        end else if (rx_idle > 0) begin
            res_ch.ready <= 1'b0;
            rx_idle--;
        end else if ($urandom_range(0, 3) == 0) begin
            res_ch.ready <= 1'b0;
            rx_idle = $urandom_range(0, 7);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // The long hold-off is counted here, in cycles.
    initial begin : long_stall
        int cnt;
        @(posedge i_rst_n);
        repeat (4000) @(posedge i_clk);
        hold_long <= 1'b1;
        for (cnt = 0; cnt < 400; cnt++) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    // Compares each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.value !== want.value) begin
                    $error("value expected %0d actual %0d", want.value, res_ch.value);
                    fail_count++;
                end
                if (res_ch.matched !== want.matched) begin
                    $error("matched expected %0d actual %0d", want.matched, res_ch.matched);
                    fail_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, res_ch.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[piecewise_poly_curve_eval_core] ERROR");
            $finish;
        end
    end

    // Directed rows: a word and, where it is obvious, its typed-in result.
    typedef struct {
        t_word w;
        bit fixed;
        t_result r;
    } t_row;

    t_row rows[$];

    task automatic add_row(input t_word w, input bit fixed, input t_q v,
                           input logic m, input logic [1:0] st);
        t_row row;
        row.w = w; row.fixed = fixed;
        row.r.value = v; row.r.matched = m; row.r.status = st;
        rows.push_back(row);
    endtask

    initial begin : stimulus
        t_word w;
        t_result got;
        item_ch.valid = 1'b0;
        item_ch.command = '0; item_ch.position = '0; item_ch.fallback_value = '0;
        item_ch.coeff_a = '0; item_ch.coeff_b = '0; item_ch.coeff_c = '0;
        item_ch.coeff_d = '0; item_ch.coeff_count = '0;
        item_ch.bound_low = '0; item_ch.bound_high = '0;
        tbl_used = 0;
        sh_gain = GAIN_RESET; sh_bias = BIAS_RESET; sh_limit = LIMIT_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: fallback passes straight through at unit gain.
        w = blank_word(CMD_EVAL); w.fb = Q_MAX; add_row(w, 1, Q_MAX, 0, ST_OK);
        w = blank_word(CMD_EVAL); w.fb = Q_MIN; add_row(w, 1, Q_MIN, 0, ST_OK);
        // Zero coefficients and zero-length spline are rejected.
        w = blank_word(CMD_POLY); w.cnt = 0; w.hi = Q_MAX; add_row(w, 1, 0, 0, ST_NOCOEF);
        w = blank_word(CMD_HERM); w.lo = 32'sd65536; w.hi = 32'sd65536;
        add_row(w, 1, 0, 0, ST_ZEROLEN);
        // The NOP command does nothing.
        w = blank_word(CMD_NOP); w.ca = Q_MAX; w.cnt = 3'd7; add_row(w, 1, 0, 0, ST_OK);
        // Constant segment, then a lookup inside it and one at the exclusive top.
        w = blank_word(CMD_POLY); w.ca = 32'sd196608; w.cnt = 1;
        w.lo = 0; w.hi = 32'sd65536; add_row(w, 1, 0, 0, ST_OK);
        w = blank_word(CMD_EVAL); w.pos = 0; add_row(w, 1, 32'sd196608, 1, ST_OK);
        w = blank_word(CMD_EVAL); w.pos = 32'sd65536; w.fb = 32'sd7;
        add_row(w, 1, 32'sd7, 0, ST_OK);
        // Too many coefficients saturate to four; extreme coefficients saturate.
        w = blank_word(CMD_POLY); w.ca = Q_MAX; w.cb = Q_MAX; w.cc = Q_MIN; w.cd = Q_MAX;
        w.cnt = 3'd7; w.lo = Q_MIN; w.hi = Q_MAX; add_row(w, 0, 0, 0, ST_OK);
        w = blank_word(CMD_EVAL); w.pos = Q_MAX - 1; add_row(w, 0, 0, 0, ST_OK);
        w = blank_word(CMD_EVAL); w.pos = Q_MIN; add_row(w, 0, 0, 0, ST_OK);
        // Hermite loads with extreme and ordinary slopes and lengths.
        w = blank_word(CMD_HERM); w.ca = Q_MIN; w.cb = Q_MAX; w.cc = Q_MAX; w.cd = Q_MIN;
        w.lo = Q_MIN; w.hi = Q_MAX; add_row(w, 0, 0, 0, ST_OK);
        w = blank_word(CMD_HERM); w.ca = 32'sd65536; w.cb = 32'sd131072;
        w.cc = -32'sd65536; w.cd = 0; w.lo = 32'sd131072; w.hi = 32'sd1; add_row(w, 0, 0, 0, ST_OK);
        w = blank_word(CMD_EVAL); w.pos = 32'sd100; add_row(w, 0, 0, 0, ST_OK);
        // Fill the table; the next valid load reports full, a bad one its own error.
        for (int i = 0; i < 12; i++) begin
            w = blank_word(CMD_POLY); w.ca = t_q'(i); w.cnt = 2;
            w.lo = t_q'(i * 65536); w.hi = t_q'(i * 65536 + 100); add_row(w, 0, 0, 0, ST_OK);
        end
        w = blank_word(CMD_POLY); w.cnt = 4; add_row(w, 1, 0, 0, ST_FULL);
        w = blank_word(CMD_HERM); w.hi = 32'sd5; add_row(w, 1, 0, 0, ST_FULL);
        w = blank_word(CMD_POLY); w.cnt = 0; add_row(w, 1, 0, 0, ST_NOCOEF);

        foreach (rows[i]) begin
            offer_word(rows[i].w);
            if (rows[i].fixed) begin
                // The typed-in value stands in for the predicted one.
                got = pending_results.pop_back();
                if (got.value !== rows[i].r.value || got.matched !== rows[i].r.matched ||
                    got.status !== rows[i].r.status) begin
                    $error("row %0d table entry disagrees with the predictor", i);
                    fail_count++;
                end
                pending_results.push_back(rows[i].r);
            end
        end

        // Random part in phases, each with its own register setting, on the table
        // that the directed rows left behind.
        for (int ph = 0; ph < 6; ph++) begin
            settle_idle();
            case (ph)
                0: begin
                    write_reg(CFG_GAIN, Q_MAX); write_reg(CFG_BIAS, Q_MIN);
                    write_reg(CFG_LIMIT, Q_MAX);
                end
                1: begin
                    write_reg(CFG_GAIN, Q_MIN); write_reg(CFG_BIAS, Q_MAX);
                    write_reg(CFG_LIMIT, 32'sd65536);
                end
                2: begin
                    write_reg(CFG_GAIN, GAIN_RESET); write_reg(CFG_BIAS, BIAS_RESET);
                    write_reg(CFG_LIMIT, Q_MIN);
                end
                3: begin
                    write_reg(CFG_GAIN, 32'sd32768); write_reg(CFG_BIAS, -32'sd65536);
                    write_reg(CFG_LIMIT, 32'sd1);
                end
                default: begin
                    write_reg(CFG_GAIN, t_q'($urandom)); write_reg(CFG_BIAS, t_q'($urandom));
                    write_reg(CFG_LIMIT, t_q'($urandom_range(0, 1 << 20)));
                end
            endcase
            for (int i = 0; i < RANDOM_WORDS / 6; i++) begin
                w = random_word();
                offer_word(w);
            end
        end

        // Last part: no idling on either side.
        calm = 1'b1;
        for (int i = 0; i < CALM_WORDS; i++) offer_word(random_word());
        item_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[piecewise_poly_curve_eval_core] OK");
        end else begin
            $display("[piecewise_poly_curve_eval_core] ERROR");
        end
        $finish;
    end
endmodule
